[hw/rtl/bkrp_pkg.sv]
// Package for the braille key report parser: event and group codes,
// parser state and result structs, key code tables.
// No dependencies.
package bkrp_pkg;

   localparam int BYTE_W   = 8;
   localparam int KEYS_W   = 15;
   localparam int CELL_W   = 7;
   localparam int COLS_W   = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [COLS_W-1:0] COLS_RESET = 7'd40;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd1;

   localparam logic [BYTE_W-1:0] GRP_OPER_BYTE = 8'h71;
   localparam logic [BYTE_W-1:0] GRP_DISP_BYTE = 8'h72;
   localparam logic [BYTE_W-1:0] ROUTE_MAX     = 8'h5F;
   localparam logic [BYTE_W-1:0] OPER_MAX      = 8'h09;
   localparam logic [BYTE_W-1:0] STAT_MAKE_LO  = 8'h20;
   localparam logic [BYTE_W-1:0] STAT_MAKE_HI  = 8'h25;
   localparam logic [BYTE_W-1:0] OPER_BRK_LO   = 8'h80;
   localparam logic [BYTE_W-1:0] OPER_BRK_HI   = 8'h89;
   localparam logic [BYTE_W-1:0] STAT_BRK_LO   = 8'hA0;
   localparam logic [BYTE_W-1:0] STAT_BRK_HI   = 8'hA5;
   localparam logic [BYTE_W-1:0] DIRECT_ROUTE_BASE = 8'd168;
   localparam logic [KEYS_W-1:0] ROUTE_KEY_BIT = 15'h0400;

   typedef enum logic [1:0] {
      EV_KEYS    = 2'd0,
      EV_RESTART = 2'd1,
      EV_GARBAGE = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      GRP_NONE = 2'd0,
      GRP_OPER = 2'd1,
      GRP_DISP = 2'd2
   } group_type;

   typedef struct packed {
      group_type         pending;
      logic [1:0]        ident_cnt;
      logic [KEYS_W-1:0] keys;
      logic [CELL_W-1:0] route;
   } state_type;

   typedef struct packed {
      logic      emit;
      event_type kind;
   } result_type;

   typedef struct packed {
      logic              old_mode;
      logic [COLS_W-1:0] cols;
   } cfg_type;

   // operating key codes 0..9; first four are reversed
   function automatic logic [KEYS_W-1:0] oper_code(input logic [3:0] idx);
      logic [KEYS_W-1:0] r;
      case (idx)
         4'd0: r = 15'h0008;
         4'd1: r = 15'h0004;
         4'd2: r = 15'h0002;
         4'd3: r = 15'h0001;
         4'd4: r = 15'h0010;
         4'd5: r = 15'h0020;
         4'd6: r = 15'h0040;
         4'd7: r = 15'h0080;
         4'd8: r = 15'h0100;
         4'd9: r = 15'h0200;
         default: r = '0;
      endcase
      return r;
   endfunction

   // status keys A..F: index+1 in bits 14:12 (codes overlap)
   function automatic logic [KEYS_W-1:0] stat_code(input logic [2:0] idx);
      logic [2:0] v;
      v = idx + 3'd1;
      return {v, 12'h000};
   endfunction

   function automatic logic [BYTE_W-1:0] ident_byte(input logic [1:0] cnt);
      logic [BYTE_W-1:0] r;
      case (cnt)
         2'd0: r = 8'h1B;
         2'd1: r = 8'h49;
         2'd2: r = 8'h44;
         2'd3: r = 8'h3D;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/bkrp_req_if.sv]
// Input channel: one received byte per word, valid/ready handshake.
// Depends on bkrp_pkg.
interface bkrp_req_if;
   logic                        valid;
   logic                        ready;
   logic [bkrp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/bkrp_rsp_if.sv]
// Result channel: event kind, key mask and routing position per word.
// Depends on bkrp_pkg.
interface bkrp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  event_kind;
   logic [bkrp_pkg::KEYS_W-1:0] key_mask;
   logic [bkrp_pkg::CELL_W-1:0] routing_pos;

   modport source (output valid, output event_kind, output key_mask,
                   output routing_pos, input ready);
   modport sink   (input valid, input event_kind, input key_mask,
                   input routing_pos, output ready);
endinterface

[hw/rtl/bkrp_decode.sv]
// Byte decoder: next parser state and result for one received byte.
// Purely combinational; depends on bkrp_pkg.
module bkrp_decode (
   input  bkrp_pkg::cfg_type            cfg,
   input  bkrp_pkg::state_type          cur,
   input  logic [bkrp_pkg::BYTE_W-1:0]  rx_byte,
   output bkrp_pkg::state_type          nxt,
   output bkrp_pkg::result_type         res
);

   logic [8:0] c9;
   logic [8:0] sbase;
   logic [8:0] sdiff;
   logic [7:0] rdiff;

   assign c9    = {1'b0, rx_byte};
   assign sbase = {1'b0, bkrp_pkg::DIRECT_ROUTE_BASE} + {2'b00, cfg.cols};
   assign sdiff = c9 - sbase;
   assign rdiff = rx_byte - bkrp_pkg::DIRECT_ROUTE_BASE;

   always_comb begin
      nxt      = cur;
      res.emit = 1'b1;
      res.kind = bkrp_pkg::EV_KEYS;
      if (cfg.old_mode) begin
         if (c9 >= sbase && sdiff < 9'd6) begin
            nxt.keys = cur.keys | bkrp_pkg::stat_code(sdiff[2:0]);
         end else if (rx_byte >= bkrp_pkg::DIRECT_ROUTE_BASE) begin
            nxt.route = rdiff[6:0];
            nxt.keys  = cur.keys | bkrp_pkg::ROUTE_KEY_BIT;
         end else begin
            nxt.keys = {7'd0, rx_byte};
         end
      end else begin
         case (cur.pending)
            bkrp_pkg::GRP_OPER: begin
               nxt.pending = bkrp_pkg::GRP_NONE;
               if (rx_byte <= bkrp_pkg::OPER_MAX) begin
                  nxt.keys = cur.keys | bkrp_pkg::oper_code(rx_byte[3:0]);
               end else if (rx_byte >= bkrp_pkg::STAT_MAKE_LO &&
                            rx_byte <= bkrp_pkg::STAT_MAKE_HI) begin
                  nxt.keys = cur.keys | bkrp_pkg::stat_code(rx_byte[2:0]);
               end else if (rx_byte >= bkrp_pkg::OPER_BRK_LO &&
                            rx_byte <= bkrp_pkg::OPER_BRK_HI) begin
                  nxt.keys = cur.keys & ~bkrp_pkg::oper_code(rx_byte[3:0]);
               end else if (rx_byte >= bkrp_pkg::STAT_BRK_LO &&
                            rx_byte <= bkrp_pkg::STAT_BRK_HI) begin
                  nxt.keys = cur.keys & ~bkrp_pkg::stat_code(rx_byte[2:0]);
               end else begin
                  nxt.keys = '0;
               end
            end
            bkrp_pkg::GRP_DISP: begin
               nxt.pending = bkrp_pkg::GRP_NONE;
               if (rx_byte <= bkrp_pkg::ROUTE_MAX) begin
                  nxt.route = rx_byte[6:0];
                  nxt.keys  = cur.keys | bkrp_pkg::ROUTE_KEY_BIT;
               end else begin
                  nxt.keys = cur.keys & ~bkrp_pkg::ROUTE_KEY_BIT;
               end
            end
            default: begin
               // no group pending; a stray code counts as none
               nxt.pending = bkrp_pkg::GRP_NONE;
               if (rx_byte == bkrp_pkg::GRP_OPER_BYTE) begin
                  nxt.pending   = bkrp_pkg::GRP_OPER;
                  nxt.ident_cnt = 2'd0;
                  res.emit      = 1'b0;
               end else if (rx_byte == bkrp_pkg::GRP_DISP_BYTE) begin
                  nxt.pending   = bkrp_pkg::GRP_DISP;
                  nxt.ident_cnt = 2'd0;
                  res.emit      = 1'b0;
               end else if (rx_byte == bkrp_pkg::ident_byte(cur.ident_cnt)) begin
                  nxt.ident_cnt = cur.ident_cnt + 2'd1;
                  if (cur.ident_cnt == 2'd3) begin
                     nxt.keys  = '0;
                     nxt.route = '0;
                     res.kind  = bkrp_pkg::EV_RESTART;
                  end else begin
                     res.emit = 1'b0;
                  end
               end else begin
                  nxt.keys = '0;
                  res.kind = bkrp_pkg::EV_GARBAGE;
               end
            end
         endcase
      end
   end

endmodule

[hw/rtl/braille_key_report_parser.sv]
// Top level of the braille key report parser: input register, decoder,
// parser state and result register. Depends on bkrp_pkg, bkrp_req_if,
// bkrp_rsp_if and bkrp_decode.
//
//   port     dir   word contents
//   req_bus  in    rx_byte (8)
//   rsp_bus  out   event_kind (2), key_mask (15), routing_pos (7)
//   csr_*    in    write enable, index (0 mode, 1 display cols), data (7)
//
// One byte per cycle while results are not stalled; a byte is decoded in the
// cycle after it is taken, and its result is registered when it advances.
// Reset clears the parser state and loads the register defaults.
// A stalled result holds the decoder; a byte that gives no result still
// passes while the result register is full.
module braille_key_report_parser (
   input  logic                              clock,
   input  logic                              reset,
   bkrp_req_if.sink                          req_bus,
   bkrp_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [bkrp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bkrp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bkrp_pkg::cfg_type    cfg_ff;
   bkrp_pkg::state_type  st_ff, st_in;
   bkrp_pkg::result_type res;

   logic                        in_vld_ff;
   logic [bkrp_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        out_vld_ff, out_vld_in;
   bkrp_pkg::event_type         out_kind_ff;
   logic [bkrp_pkg::KEYS_W-1:0] out_keys_ff;
   logic [bkrp_pkg::CELL_W-1:0] out_cell_ff;
   logic                        advance;

   bkrp_decode u_decode (
      .cfg     (cfg_ff),
      .cur     (st_ff),
      .rx_byte (in_byte_ff),
      .nxt     (st_in),
      .res     (res)
   );

   assign advance = in_vld_ff && (!res.emit || !out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !in_vld_ff || advance;

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_bus.ready;
      if (advance && res.emit) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.old_mode <= 1'b0;
         cfg_ff.cols     <= bkrp_pkg::COLS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bkrp_pkg::CSR_MODE: cfg_ff.old_mode <= csr_wdata[0];
            bkrp_pkg::CSR_COLS: cfg_ff.cols     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         st_ff.pending   <= bkrp_pkg::GRP_NONE;
         st_ff.ident_cnt <= 2'd0;
         st_ff.keys      <= '0;
         st_ff.route     <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (req_bus.ready) begin
            in_vld_ff <= req_bus.valid;
         end
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.rx_byte;
      end
      if (advance && res.emit) begin
         out_kind_ff <= res.kind;
         out_keys_ff <= st_in.keys;
         out_cell_ff <= st_in.route;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.event_kind  = out_kind_ff;
   assign rsp_bus.key_mask    = out_keys_ff;
   assign rsp_bus.routing_pos = out_cell_ff;

endmodule
